@@ hdl/cgs_pkg.sv @@
`default_nettype none
package cgs_pkg;

	localparam int TIMER_BITS_DEF = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GATE_MODE       = 3'd0,
		REG_BELL_ONLY_DROP  = 3'd1,
		REG_MAIN_DROP_DELAY = 3'd2,
		REG_MAIN_DROP_TIME  = 3'd3,
		REG_EXIT_DROP_DELAY = 3'd4,
		REG_EXIT_DROP_TIME  = 3'd5,
		REG_EXIT_RISE_LEAD  = 3'd6,
		REG_GATE_RISE_TIME  = 3'd7
	} reg_idx_t;

	localparam logic [2:0] MODE_NONE       = 3'd0;
	localparam logic [2:0] MODE_TWO_NODLY  = 3'd1;
	localparam logic [2:0] MODE_TWO_DLY    = 3'd2;
	localparam logic [2:0] MODE_FOUR_DLY   = 3'd3;
	localparam logic [2:0] MODE_FOUR_SIMUL = 3'd4;

	localparam logic [7:0] RST_MAIN_DROP_DELAY = 8'd40;
	localparam logic [7:0] RST_MAIN_DROP_TIME  = 8'd100;
	localparam logic [7:0] RST_EXIT_DROP_DELAY = 8'd20;
	localparam logic [7:0] RST_EXIT_DROP_TIME  = 8'd100;
	localparam logic [7:0] RST_EXIT_RISE_LEAD  = 8'd50;
	localparam logic [7:0] RST_GATE_RISE_TIME  = 8'd100;

	typedef enum logic [3:0] {
		PH_IDLE            = 4'd0,
		PH_START_SETUP     = 4'd1,
		PH_START           = 4'd2,
		PH_MAIN_DOWN_SETUP = 4'd3,
		PH_MAIN_DOWN       = 4'd4,
		PH_EXIT_WAIT_SETUP = 4'd5,
		PH_EXIT_WAIT       = 4'd6,
		PH_EXIT_DOWN_SETUP = 4'd7,
		PH_EXIT_DOWN       = 4'd8,
		PH_ACTIVE_TWO      = 4'd9,
		PH_ACTIVE_FOUR     = 4'd10,
		PH_ACTIVE_NOGATE   = 4'd11,
		PH_EXIT_UP_SETUP   = 4'd12,
		PH_EXIT_UP         = 4'd13,
		PH_MAIN_UP_SETUP   = 4'd14,
		PH_MAIN_UP         = 4'd15
	} phase_t;

	typedef struct packed {
		logic lights;
		logic bell;
		logic mains;
		logic exits;
	} flags_t;

	typedef struct packed {
		logic [2:0] gate_mode;
		logic       bell_only_during_drop;
		logic [7:0] main_drop_delay;
		logic [7:0] main_drop_time;
		logic [7:0] exit_drop_delay;
		logic [7:0] exit_drop_time;
		logic [7:0] exit_rise_lead;
		logic [7:0] gate_rise_time;
	} cfg_t;

endpackage
`default_nettype wire

@@ hdl/cgs_cfg.sv @@
`default_nettype none
module cgs_cfg
	import cgs_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gate_mode             <= MODE_NONE;
			cfg_q.bell_only_during_drop <= 1'b0;
			cfg_q.main_drop_delay       <= RST_MAIN_DROP_DELAY;
			cfg_q.main_drop_time        <= RST_MAIN_DROP_TIME;
			cfg_q.exit_drop_delay       <= RST_EXIT_DROP_DELAY;
			cfg_q.exit_drop_time        <= RST_EXIT_DROP_TIME;
			cfg_q.exit_rise_lead        <= RST_EXIT_RISE_LEAD;
			cfg_q.gate_rise_time        <= RST_GATE_RISE_TIME;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_GATE_MODE:       cfg_q.gate_mode <= cfg_data[2:0];
				REG_BELL_ONLY_DROP:  cfg_q.bell_only_during_drop <= cfg_data[0];
				REG_MAIN_DROP_DELAY: cfg_q.main_drop_delay <= cfg_data;
				REG_MAIN_DROP_TIME:  cfg_q.main_drop_time <= cfg_data;
				REG_EXIT_DROP_DELAY: cfg_q.exit_drop_delay <= cfg_data;
				REG_EXIT_DROP_TIME:  cfg_q.exit_drop_time <= cfg_data;
				REG_EXIT_RISE_LEAD:  cfg_q.exit_rise_lead <= cfg_data;
				REG_GATE_RISE_TIME:  cfg_q.gate_rise_time <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

@@ hdl/cgs_step.sv @@
`default_nettype none
module cgs_step
	import cgs_pkg::*;
#(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  wire cfg_t             cfg,
	input  wire logic             act,
	input  wire logic             tick,
	input  wire phase_t           phase_cur,
	input  wire logic [TIMER_BITS-1:0] cnt_cur,
	input  wire flags_t           flags_cur,
	output phase_t                phase_nxt,
	output logic [TIMER_BITS-1:0] cnt_nxt,
	output flags_t                flags_nxt
);

	localparam int TW = (TIMER_BITS > 8) ? TIMER_BITS : 8;
	localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

	function automatic logic [TIMER_BITS-1:0] load(input logic [7:0] v);
		logic [TW-1:0] wide;
		wide = TW'(v);
		if (wide > TW'(TMAX))
			return TMAX;
		return wide[TIMER_BITS-1:0];
	endfunction

	logic gates, four, quiet;
	logic [TIMER_BITS-1:0] cnt_dec;

	assign gates = cfg.gate_mode != MODE_NONE;
	assign four  = (cfg.gate_mode == MODE_FOUR_DLY) || (cfg.gate_mode == MODE_FOUR_SIMUL);
	assign quiet = gates && cfg.bell_only_during_drop;
	assign cnt_dec = (tick && cnt_cur != '0) ? cnt_cur - 1'b1 : cnt_cur;

	always_comb begin
		phase_nxt = phase_cur;
		cnt_nxt   = cnt_dec;
		flags_nxt = flags_cur;
		unique case (phase_cur)
			PH_IDLE: begin
				if (act) phase_nxt = PH_START_SETUP;
				else flags_nxt = '0;
			end
			PH_START_SETUP: begin
				flags_nxt = '{lights: 1'b1, bell: 1'b1, mains: 1'b0, exits: 1'b0};
				cnt_nxt = (gates && cfg.gate_mode != MODE_TWO_NODLY) ?
					load(cfg.main_drop_delay) : '0;
				phase_nxt = PH_START;
			end
			PH_START: begin
				flags_nxt.lights = 1'b1;
				flags_nxt.bell   = 1'b1;
				if (!act) phase_nxt = PH_IDLE;
				else if (cnt_dec == '0)
					phase_nxt = gates ? PH_MAIN_DOWN_SETUP : PH_ACTIVE_NOGATE;
			end
			PH_MAIN_DOWN_SETUP: begin
				if (!act) begin
					phase_nxt = PH_IDLE;
				end else begin
					flags_nxt = '{lights: 1'b1, bell: 1'b1, mains: 1'b1, exits: 1'b0};
					cnt_nxt = load(cfg.main_drop_time);
					phase_nxt = PH_MAIN_DOWN;
				end
			end
			PH_MAIN_DOWN: begin
				flags_nxt.mains = 1'b1;
				flags_nxt.exits = 1'b0;
				if (!act) phase_nxt = PH_MAIN_UP_SETUP;
				else if (cnt_dec == '0)
					phase_nxt = four ? PH_EXIT_WAIT_SETUP : PH_ACTIVE_TWO;
			end
			PH_EXIT_WAIT_SETUP: begin
				flags_nxt.mains  = 1'b1;
				flags_nxt.lights = 1'b1;
				flags_nxt.bell   = 1'b1;
				if (!act) begin
					phase_nxt = PH_MAIN_UP_SETUP;
				end else begin
					cnt_nxt = load(cfg.exit_drop_delay);
					phase_nxt = PH_EXIT_WAIT;
				end
			end
			PH_EXIT_WAIT: begin
				flags_nxt.mains  = 1'b1;
				flags_nxt.lights = 1'b1;
				flags_nxt.bell   = 1'b1;
				if (!act) phase_nxt = PH_MAIN_UP_SETUP;
				else if (cnt_dec == '0) phase_nxt = PH_EXIT_DOWN_SETUP;
			end
			PH_EXIT_DOWN_SETUP: begin
				flags_nxt.mains  = 1'b1;
				flags_nxt.lights = 1'b1;
				flags_nxt.bell   = 1'b1;
				if (!act) begin
					phase_nxt = PH_MAIN_UP_SETUP;
				end else begin
					cnt_nxt = load(cfg.exit_drop_time);
					phase_nxt = PH_EXIT_DOWN;
				end
			end
			PH_EXIT_DOWN: begin
				flags_nxt = '1;
				if (!act) phase_nxt = PH_EXIT_UP_SETUP;
				else if (cnt_dec == '0) phase_nxt = PH_ACTIVE_FOUR;
			end
			PH_ACTIVE_TWO: begin
				flags_nxt = '{lights: 1'b1, bell: !quiet, mains: 1'b1, exits: 1'b0};
				if (!act) phase_nxt = PH_MAIN_UP_SETUP;
			end
			PH_ACTIVE_FOUR: begin
				flags_nxt = '{lights: 1'b1, bell: !quiet, mains: 1'b1, exits: 1'b1};
				if (!act) phase_nxt = PH_EXIT_UP_SETUP;
			end
			PH_ACTIVE_NOGATE: begin
				flags_nxt = '{lights: 1'b1, bell: !quiet, mains: 1'b0, exits: 1'b0};
				if (!act) phase_nxt = PH_IDLE;
			end
			PH_EXIT_UP_SETUP: begin
				flags_nxt.exits = 1'b0;
				if (cfg.gate_mode == MODE_FOUR_DLY) begin
					cnt_nxt = load(cfg.exit_rise_lead);
				end else begin
					cnt_nxt = '0;
					flags_nxt.mains = 1'b0;
				end
				phase_nxt = PH_EXIT_UP;
			end
			PH_EXIT_UP: begin
				flags_nxt.exits = 1'b0;
				if (act) phase_nxt = PH_MAIN_DOWN_SETUP;
				else if (cnt_dec == '0) phase_nxt = PH_MAIN_UP_SETUP;
			end
			PH_MAIN_UP_SETUP: begin
				flags_nxt.mains = 1'b0;
				flags_nxt.exits = 1'b0;
				cnt_nxt = gates ? load(cfg.gate_rise_time) : '0;
				phase_nxt = PH_MAIN_UP;
			end
			PH_MAIN_UP: begin
				flags_nxt.mains = 1'b0;
				flags_nxt.exits = 1'b0;
				if (cnt_dec == '0) phase_nxt = PH_IDLE;
			end
			default: phase_nxt = PH_IDLE;
		endcase
	end

endmodule
`default_nettype wire

@@ hdl/crossing_gate_sequencer_unit.sv @@
// An item is first held in the input register; its result is registered when it advances.
// Throughput: one item per cycle unless out_ready stalls the result; the phase and countdown update is combinational.
// An input register and the result register sit between the channels; when both
// are full, in_ready follows out_ready in the same cycle.
// Reset (arst_n low, asynchronous) sets the phase to idle, the countdown and
// all drive flags to zero, and the timing registers to their default values.
`default_nettype none
module crossing_gate_sequencer_unit
	import cgs_pkg::*;
#(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  train_present,
	input  wire logic                  tenth_tick,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       lights_on,
	output logic                       bell_on,
	output logic                       main_gates_down,
	output logic                       exit_gates_down,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg;

	logic valid_s1, act_s1, tick_s1;
	logic advance;

	phase_t phase_q, phase_nxt;
	logic [TIMER_BITS-1:0] cnt_q, cnt_nxt;
	flags_t flags_q, flags_nxt;
	logic out_valid_q;

	cgs_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			act_s1  <= train_present;
			tick_s1 <= tenth_tick;
		end
	end

	cgs_step #(
		.TIMER_BITS(TIMER_BITS)
	) u_step (
		.cfg      (cfg),
		.act      (act_s1),
		.tick     (tick_s1),
		.phase_cur(phase_q),
		.cnt_cur  (cnt_q),
		.flags_cur(flags_q),
		.phase_nxt(phase_nxt),
		.cnt_nxt  (cnt_nxt),
		.flags_nxt(flags_nxt)
	);

	// The flags are both sequencer state and the result payload; they change only
	// when the result register is free, so a stalled result holds.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			cnt_q       <= '0;
			flags_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				phase_q <= phase_nxt;
				cnt_q   <= cnt_nxt;
				flags_q <= flags_nxt;
			end
			if (advance)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid       = out_valid_q;
	assign lights_on       = flags_q.lights;
	assign bell_on         = flags_q.bell;
	assign main_gates_down = flags_q.mains;
	assign exit_gates_down = flags_q.exits;

`ifndef SYNTH
	a_exit_needs_main: assert property (@(posedge clk) disable iff (!arst_n)
		flags_q.exits |-> flags_q.mains)
		else $error("exit gates down while main gates up");

	a_bell_needs_lights: assert property (@(posedge clk) disable iff (!arst_n)
		flags_q.bell |-> flags_q.lights)
		else $error("bell on without lights");

	a_advance_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("processed item produced no result");

	a_state_holds_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> ($stable(phase_q) && $stable(cnt_q) && $stable(flags_q)))
		else $error("state changed without an item");
`endif

endmodule
`default_nettype wire

@@ tb/crossing_gate_sequencer_unit_tb.sv @@
`timescale 1ns / 100ps
module crossing_gate_sequencer_unit_tb;
	import cgs_pkg::*;

	class gate_flag_board;
		cfg_t regs;
		phase_t ph;
		logic [7:0] count;
		flags_t fl;
		flags_t expected_flags[$];
		int errors;

		function new();
			regs.gate_mode = MODE_NONE;
			regs.bell_only_during_drop = 1'b0;
			regs.main_drop_delay = RST_MAIN_DROP_DELAY;
			regs.main_drop_time = RST_MAIN_DROP_TIME;
			regs.exit_drop_delay = RST_EXIT_DROP_DELAY;
			regs.exit_drop_time = RST_EXIT_DROP_TIME;
			regs.exit_rise_lead = RST_EXIT_RISE_LEAD;
			regs.gate_rise_time = RST_GATE_RISE_TIME;
			ph = PH_IDLE;
			count = '0;
			fl = '0;
			errors = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [7:0] d);
			case (idx)
				REG_GATE_MODE: regs.gate_mode = d[2:0];
				REG_BELL_ONLY_DROP: regs.bell_only_during_drop = d[0];
				REG_MAIN_DROP_DELAY: regs.main_drop_delay = d;
				REG_MAIN_DROP_TIME: regs.main_drop_time = d;
				REG_EXIT_DROP_DELAY: regs.exit_drop_delay = d;
				REG_EXIT_DROP_TIME: regs.exit_drop_time = d;
				REG_EXIT_RISE_LEAD: regs.exit_rise_lead = d;
				REG_GATE_RISE_TIME: regs.gate_rise_time = d;
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_flags.size();
		endfunction

		// Flag vectors below are ordered lights, bell, main gates, exit gates.
		function void note_input(logic act, logic tick);
			bit gates;
			bit four;
			bit quiet;
			gates = regs.gate_mode != MODE_NONE;
			four = regs.gate_mode == MODE_FOUR_DLY || regs.gate_mode == MODE_FOUR_SIMUL;
			quiet = gates && regs.bell_only_during_drop;
			if (tick && count != 0)
				count = count - 8'd1;
			case (ph)
				PH_IDLE: begin
					if (act)
						ph = PH_START_SETUP;
					else
						fl = 4'b0000;
				end
				PH_START_SETUP: begin
					fl = 4'b1100;
					count = (gates && regs.gate_mode != MODE_TWO_NODLY) ?
						regs.main_drop_delay : 8'd0;
					ph = PH_START;
				end
				PH_START: begin
					fl.lights = 1'b1;
					fl.bell = 1'b1;
					if (!act)
						ph = PH_IDLE;
					else if (count == 0)
						ph = gates ? PH_MAIN_DOWN_SETUP : PH_ACTIVE_NOGATE;
				end
				PH_MAIN_DOWN_SETUP: begin
					if (!act) begin
						ph = PH_IDLE;
					end else begin
						fl = 4'b1110;
						count = regs.main_drop_time;
						ph = PH_MAIN_DOWN;
					end
				end
				PH_MAIN_DOWN: begin
					fl.mains = 1'b1;
					fl.exits = 1'b0;
					if (!act)
						ph = PH_MAIN_UP_SETUP;
					else if (count == 0)
						ph = four ? PH_EXIT_WAIT_SETUP : PH_ACTIVE_TWO;
				end
				PH_EXIT_WAIT_SETUP: begin
					fl.lights = 1'b1;
					fl.bell = 1'b1;
					fl.mains = 1'b1;
					if (!act) begin
						ph = PH_MAIN_UP_SETUP;
					end else begin
						count = regs.exit_drop_delay;
						ph = PH_EXIT_WAIT;
					end
				end
				PH_EXIT_WAIT: begin
					fl.lights = 1'b1;
					fl.bell = 1'b1;
					fl.mains = 1'b1;
					if (!act)
						ph = PH_MAIN_UP_SETUP;
					else if (count == 0)
						ph = PH_EXIT_DOWN_SETUP;
				end
				PH_EXIT_DOWN_SETUP: begin
					fl.lights = 1'b1;
					fl.bell = 1'b1;
					fl.mains = 1'b1;
					if (!act) begin
						ph = PH_MAIN_UP_SETUP;
					end else begin
						count = regs.exit_drop_time;
						ph = PH_EXIT_DOWN;
					end
				end
				PH_EXIT_DOWN: begin
					fl = 4'b1111;
					if (!act)
						ph = PH_EXIT_UP_SETUP;
					else if (count == 0)
						ph = PH_ACTIVE_FOUR;
				end
				PH_ACTIVE_TWO: begin
					fl = {1'b1, !quiet, 1'b1, 1'b0};
					if (!act)
						ph = PH_MAIN_UP_SETUP;
				end
				PH_ACTIVE_FOUR: begin
					fl = {1'b1, !quiet, 1'b1, 1'b1};
					if (!act)
						ph = PH_EXIT_UP_SETUP;
				end
				PH_ACTIVE_NOGATE: begin
					fl = {1'b1, !quiet, 1'b0, 1'b0};
					if (!act)
						ph = PH_IDLE;
				end
				PH_EXIT_UP_SETUP: begin
					fl.exits = 1'b0;
					if (regs.gate_mode == MODE_FOUR_DLY) begin
						count = regs.exit_rise_lead;
					end else begin
						count = '0;
						fl.mains = 1'b0;
					end
					ph = PH_EXIT_UP;
				end
				PH_EXIT_UP: begin
					fl.exits = 1'b0;
					if (act)
						ph = PH_MAIN_DOWN_SETUP;
					else if (count == 0)
						ph = PH_MAIN_UP_SETUP;
				end
				PH_MAIN_UP_SETUP: begin
					fl.mains = 1'b0;
					fl.exits = 1'b0;
					count = gates ? regs.gate_rise_time : 8'd0;
					ph = PH_MAIN_UP;
				end
				PH_MAIN_UP: begin
					fl.mains = 1'b0;
					fl.exits = 1'b0;
					if (count == 0)
						ph = PH_IDLE;
				end
				default: ph = PH_IDLE;
			endcase
			expected_flags.push_back(fl);
		endfunction

		function void check_result(flags_t got);
			flags_t want;
			if (expected_flags.size() == 0) begin
				$error("result transfer with no expected result: %b", got);
				errors++;
				return;
			end
			want = expected_flags.pop_front();
			if (got.lights !== want.lights) begin
				$error("lights_on: expected %0b, actual %0b", want.lights, got.lights);
				errors++;
			end
			if (got.bell !== want.bell) begin
				$error("bell_on: expected %0b, actual %0b", want.bell, got.bell);
				errors++;
			end
			if (got.mains !== want.mains) begin
				$error("main_gates_down: expected %0b, actual %0b", want.mains, got.mains);
				errors++;
			end
			if (got.exits !== want.exits) begin
				$error("exit_gates_down: expected %0b, actual %0b", want.exits, got.exits);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic train_present;
	logic tenth_tick;
	logic out_valid;
	logic out_ready;
	logic lights_on;
	logic bell_on;
	logic main_gates_down;
	logic exit_gates_down;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	gate_flag_board flag_board = new();

	int hold_request = 0;
	int hold_left = 0;
	int stall_pct = 0;
	int rx_cycle = 0;

	crossing_gate_sequencer_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.train_present(train_present),
		.tenth_tick(tenth_tick),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.lights_on(lights_on),
		.bell_on(bell_on),
		.main_gates_down(main_gates_down),
		.exit_gates_down(exit_gates_down),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			flag_board.check_result({lights_on, bell_on, main_gates_down, exit_gates_down});
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (hold_request != 0) begin
			hold_request = 0;
			hold_left = 120;
			out_ready <= 1'b0;
		end else begin
			if (rx_cycle % 64 == 0) begin
				case ($urandom_range(0, 4))
					0, 1: stall_pct = 0;
					2: stall_pct = 30;
					3: stall_pct = 60;
					default: stall_pct = 90;
				endcase
			end
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
		rx_cycle++;
	end

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic send_item(input logic act, input logic tick);
		in_valid <= 1'b1;
		train_present <= act;
		tenth_tick <= tick;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		flag_board.note_input(act, tick);
		@(negedge clk);
	endtask

	task automatic idle_gap(input int n);
		in_valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (flag_board.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [7:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(negedge clk);
		flag_board.write_reg(idx, d);
	endtask

	task automatic configure(input logic [7:0] mode_d, input logic [7:0] bell_d,
			input logic [7:0] tv[6]);
		write_reg(REG_GATE_MODE, mode_d);
		write_reg(REG_BELL_ONLY_DROP, bell_d);
		write_reg(REG_MAIN_DROP_DELAY, tv[0]);
		write_reg(REG_MAIN_DROP_TIME, tv[1]);
		write_reg(REG_EXIT_DROP_DELAY, tv[2]);
		write_reg(REG_EXIT_DROP_TIME, tv[3]);
		write_reg(REG_EXIT_RISE_LEAD, tv[4]);
		write_reg(REG_GATE_RISE_TIME, tv[5]);
		cfg_we <= 1'b0;
	endtask

	// Mostly clean occupy/clear episodes, with some short stretches of random toggling.
	task automatic run_items(input int n, input int tick_pct, input bit gaps);
		int sent;
		int run_len;
		int burst_left;
		bit noise;
		logic act;
		logic act_item;
		logic tick;
		sent = 0;
		run_len = 0;
		noise = 1'b0;
		act = 1'b0;
		burst_left = $urandom_range(1, 24);
		while (sent < n) begin
			if (run_len == 0) begin
				if ($urandom_range(0, 99) < 15) begin
					noise = 1'b1;
					run_len = $urandom_range(1, 8);
				end else begin
					noise = 1'b0;
					act = !act;
					run_len = act ? $urandom_range(1, 40) : $urandom_range(1, 30);
				end
			end
			act_item = noise ? logic'($urandom_range(0, 1)) : act;
			tick = ($urandom_range(0, 99) < tick_pct);
			send_item(act_item, tick);
			sent++;
			run_len--;
			if (gaps) begin
				burst_left--;
				if (burst_left == 0) begin
					idle_gap($urandom_range(1, 6));
					burst_left = $urandom_range(1, 24);
				end
			end
		end
	endtask

	initial begin
		logic [7:0] tv[6];
		logic [7:0] mode_d;
		logic [7:0] bell_d;
		int pct;
		in_valid = 1'b0;
		train_present = 1'b0;
		tenth_tick = 1'b0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: no gates, so the crossing only flashes and rings.
		send_item(1'b0, 1'b0);
		send_item(1'b1, 1'b1);
		send_item(1'b1, 1'b0);
		send_item(1'b1, 1'b1);
		send_item(1'b1, 1'b1);
		send_item(1'b0, 1'b1);
		send_item(1'b0, 1'b0);
		drain();

		tv = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1};
		configure({5'd0, MODE_FOUR_SIMUL}, 8'd1, tv);
		repeat (10) send_item(1'b1, 1'b1);
		repeat (6) send_item(1'b0, 1'b1);

		for (int p = 0; p < 9; p++) begin
			drain();
			mode_d = {5'($urandom()), 3'((p + 3) % 8)};
			if (p == 8)
				mode_d[2:0] = 3'($urandom_range(0, 7));
			bell_d = 8'($urandom());
			for (int i = 0; i < 6; i++) begin
				if (p == 0)
					tv[i] = 8'd0;
				else if (p == 1)
					tv[i] = 8'd255;
				else if ($urandom_range(0, 7) == 0)
					tv[i] = 8'($urandom());
				else
					tv[i] = 8'($urandom_range(0, 6));
			end
			configure(mode_d, bell_d, tv);
			pct = (p == 1) ? 100 : $urandom_range(40, 100);
			if (p == 2)
				hold_request = 1;
			run_items(140, pct, p != 2 && p != 5);
		end

		drain();
		repeat (10) @(negedge clk);
		if (flag_board.errors == 0 && flag_board.pending() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/cgs_pkg.sv
hdl/cgs_cfg.sv
hdl/cgs_step.sv
hdl/crossing_gate_sequencer_unit.sv
tb/crossing_gate_sequencer_unit_tb.sv
